// ===== sv/sabs_pkg.sv =====
// Shared types and constants for the sorted-array binary search unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sabs_pkg;

  localparam int DEPTH       = 1024;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int COUNT_W     = $clog2(DEPTH + 1);
  localparam int VALUE_WIDTH = 32;

  // Function codes of a command beat
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef struct packed {
    logic                          func;
    logic [ADDR_W-1:0]             index;
    logic signed [VALUE_WIDTH-1:0] value;
    logic [COUNT_W-1:0]            count;
  } cmd_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] position;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic                          en;
    logic [ADDR_W-1:0]             addr;
    logic signed [VALUE_WIDTH-1:0] data;
  } mem_wr_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_CMP
  } state_t;

endpackage

`default_nettype wire

// ===== sv/sorted_array_binary_search_unit.sv =====
// Sorted-array binary search unit: a 1024-entry store plus a search sequencer.
// Sequence: a write is done on the accepted start; a search makes a read step (S_CHECK) and
//   a compare step (S_CMP) per probe, at most 11 probes, and ends on a hit or an empty range.
// busy falls in the result cycle.
// Reset: rst (synchronous) returns the sequencer to idle; store contents stay.
// Results are strobed for one cycle on done; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module sorted_array_binary_search_unit (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  sabs_pkg::cmd_t     cmd,
  output logic               done,
  output sabs_pkg::result_t  result
);
  import sabs_pkg::*;

  mem_wr_t                       wr;
  mem_rd_t                       rd;
  logic signed [VALUE_WIDTH-1:0] rd_data;

  sabs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .done    (done),
    .result  (result),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  sabs_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

// ===== sv/sabs_store.sv =====
// Sorted value store: one write port, one read port, registered read data.
// Depends on sabs_pkg for depth, widths and the port structs.
`timescale 1ns / 1ps
`default_nettype none

module sabs_store (
  input  wire                                     clk,
  input  sabs_pkg::mem_wr_t                       wr,
  input  sabs_pkg::mem_rd_t                       rd,
  output logic signed [sabs_pkg::VALUE_WIDTH-1:0] rd_data
);
  import sabs_pkg::*;

  logic signed [VALUE_WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/sabs_ctrl.sv =====
// Search sequencer: takes command beats, drives store reads and writes,
// compares probes against the key and emits one result beat per search.
// Depends on sabs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sabs_ctrl (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     start,
  output logic                                    busy,
  input  sabs_pkg::cmd_t                          cmd,
  output logic                                    done,
  output sabs_pkg::result_t                       result,
  output sabs_pkg::mem_wr_t                       wr,
  output sabs_pkg::mem_rd_t                       rd,
  input  wire signed [sabs_pkg::VALUE_WIDTH-1:0]  rd_data
);
  import sabs_pkg::*;

  state_t state, state_next;

  logic [COUNT_W-1:0]            lo;
  logic [COUNT_W-1:0]            hp1;   // one past the upper bound
  logic [ADDR_W-1:0]             mid;
  logic signed [VALUE_WIDTH-1:0] key;

  logic                accept;
  logic                range_live;
  logic [COUNT_W:0]    mid_sum;
  logic [ADDR_W-1:0]   mid_calc;
  logic [COUNT_W-1:0]  cnt_sat;

  assign accept     = start && !busy;
  assign range_live = lo < hp1;
  // floor((lo + hi) / 2) with hi = hp1 - 1
  assign mid_sum    = {1'b0, lo} + {1'b0, hp1} - (COUNT_W + 1)'(1);
  assign mid_calc   = mid_sum[ADDR_W:1];
  assign cnt_sat    = (cmd.count > COUNT_W'(DEPTH)) ? COUNT_W'(DEPTH) : cmd.count;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && cmd.func == FUNC_SEARCH) state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = range_live ? S_CMP : S_IDLE;
      end
      S_CMP: begin
        state_next = (rd_data == key) ? S_IDLE : S_CHECK;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs to the handshake and the store
  always_comb begin
    busy    = (state != S_IDLE);
    wr.en   = accept && cmd.func == FUNC_WRITE;
    wr.addr = cmd.index;
    wr.data = cmd.value;
    rd.en   = (state == S_CHECK) && range_live;
    rd.addr = mid_calc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // search bounds and key
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      lo  <= '0;
      hp1 <= cnt_sat;
      key <= cmd.value;
    end else if (state == S_CHECK) begin
      mid <= mid_calc;
    end else if (state == S_CMP && rd_data != key) begin
      if (rd_data > key) begin
        hp1 <= {1'b0, mid};
      end else begin
        lo  <= {1'b0, mid} + COUNT_W'(1);
      end
    end
  end

  // result beat: one cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_CHECK && !range_live) || (state == S_CMP && rd_data == key);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CHECK && !range_live) begin
      result.found    <= 1'b0;
      result.position <= '0;
    end else if (state == S_CMP && rd_data == key) begin
      result.found    <= 1'b1;
      result.position <= mid;
    end
  end

`ifndef SYNTHESIS
  // a result only ends a search
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_CHECK || $past(state) == S_CMP))
    else $error("result beat without a search step");

  // the probe lies inside the live range
  a_mid_range: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> ({1'b0, mid} >= lo && {1'b0, mid} < hp1))
    else $error("probe outside search range");

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    done && !result.found |-> result.position == '0)
    else $error("nonzero position on miss");

  // an accepted search holds busy
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.func == FUNC_SEARCH |=> busy)
    else $error("search accepted but not busy");

  // a write never starts a search
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.func == FUNC_WRITE |=> !busy && !done)
    else $error("write beat left the sequencer busy");
`endif

endmodule

`default_nettype wire
